@@ rtl/rpe_pkg.sv @@
// ----------------------------------------------------------------------------
// rpe_pkg
// Shared types, constants and constant functions for the rotary position
// embedding pipeline.
// ----------------------------------------------------------------------------
package rpe_pkg;

    localparam int POS_W     = 16;
    localparam int IDX_W     = 7;
    localparam int HS_W      = 9;
    localparam int HALF_W    = 8;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam int FRAC_W    = 24;
    localparam int DIV_STEPS = 32;
    localparam int NUM_W     = DATA_W + IDX_W;   // log2_theta * pair index
    localparam int M_W       = 33;               // Q0.32 plus the 1.0 value
    localparam int T_W       = 43;
    localparam int P_W       = T_W + POS_W;
    localparam int CW        = 34;               // CORDIC datapath width
    localparam int PROD_W    = DATA_W + CW;
    localparam int ACC_W     = PROD_W + 1;
    localparam int RND_W     = ACC_W - 30;

    localparam int MAX_HEAD_SIZE_DEF  = 256;
    localparam int POSITION_LIMIT_DEF = 65535;
    localparam int CORDIC_STAGES_DEF  = 24;

    localparam logic [CFG_W-1:0] LOG2_THETA_RST = 32'd334396240;
    localparam logic [HS_W-1:0]  HEAD_SIZE_RST  = 9'd128;
    localparam logic [29:0]      INV_TWO_PI_Q32 = 30'd683565275;
    localparam logic [31:0]      CORDIC_START   = 32'h26DD3B6A;

    localparam logic [CFG_IDX_W-1:0] CFG_LOG2_THETA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_SIZE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_BAD = 2'd2
    } t_status;

    // sideband carried along every cell of the chain
    typedef struct packed {
        logic                     valid;
        logic                     bad;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] x_first;
        logic signed [DATA_W-1:0] x_second;
    } t_side;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] rem;
        logic [63:0] bit_v;
        res   = '0;
        rem   = x;
        bit_v = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bit_v > rem) bit_v = bit_v >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bit_v != 64'd0) begin
                if (rem >= res + bit_v) begin
                    rem = rem - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    // 2^(-2^-k) in Q0.32, by the repeated square root chain
    function automatic logic [31:0] exp_coef(input int k);
        logic [63:0] c;
        c = isqrt64(64'd1 << 63);
        for (int j = 1; j < FRAC_W; j++) begin
            if (j < k) c = isqrt64(c << 32);
        end
        return c[31:0];
    endfunction

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        unique case (i)
            0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
            12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
            18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
            21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
            24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
            27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/rpe_div_cell.sv @@
// ----------------------------------------------------------------------------
// rpe_div_cell
// One restoring division step: produces one quotient bit of the exponent.
// ----------------------------------------------------------------------------
module rpe_div_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  rpe_pkg::t_side              i_side,
    input  logic [rpe_pkg::HALF_W-1:0]  i_div,
    input  logic [rpe_pkg::HALF_W-1:0]  i_rem,
    input  logic [rpe_pkg::DATA_W-1:0]  i_num,
    output rpe_pkg::t_side              o_side,
    output logic [rpe_pkg::HALF_W-1:0]  o_div,
    output logic [rpe_pkg::HALF_W-1:0]  o_rem,
    output logic [rpe_pkg::DATA_W-1:0]  o_num
);
    import rpe_pkg::*;

    t_side              r_side;
    logic [HALF_W-1:0]  r_div;
    logic [HALF_W-1:0]  r_rem;
    logic [DATA_W-1:0]  r_num;
    logic [HALF_W:0]    w_trial;
    logic               w_ge;
    logic [HALF_W-1:0]  n_rem;

    always_comb begin
        w_trial = {i_rem, i_num[DATA_W-1]};
        w_ge    = w_trial >= {1'b0, i_div};
        // remainder stays below the divisor, so it fits HALF_W bits
        n_rem   = w_ge ? HALF_W'(w_trial - {1'b0, i_div}) : w_trial[HALF_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= i_div;
            r_rem <= n_rem;
            r_num <= {i_num[DATA_W-2:0], w_ge};
        end
    end

    assign o_side = r_side;
    assign o_div  = r_div;
    assign o_rem  = r_rem;
    assign o_num  = r_num;

endmodule

@@ rtl/rpe_exp_cell.sv @@
// ----------------------------------------------------------------------------
// rpe_exp_cell
// One fraction bit of 2^-f: multiplies by 2^(-2^-K) when bit K is set.
// ----------------------------------------------------------------------------
module rpe_exp_cell #(
    parameter int K = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  rpe_pkg::t_side              i_side,
    input  logic [rpe_pkg::DATA_W-1:0]  i_exp,
    input  logic [rpe_pkg::M_W-1:0]     i_m,
    output rpe_pkg::t_side              o_side,
    output logic [rpe_pkg::DATA_W-1:0]  o_exp,
    output logic [rpe_pkg::M_W-1:0]     o_m
);
    import rpe_pkg::*;

    localparam logic [31:0] COEF = exp_coef(K);

    t_side              r_side;
    logic [DATA_W-1:0]  r_exp;
    logic [M_W-1:0]     r_m;
    logic [M_W+31:0]    w_prod;
    logic [M_W-1:0]     n_m;

    always_comb begin
        w_prod = (M_W + 32)'(i_m) * (M_W + 32)'(COEF) + (M_W + 32)'(33'h080000000);
        n_m    = i_exp[FRAC_W - K] ? w_prod[M_W+31:32] : i_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_exp <= i_exp;
            r_m   <= n_m;
        end
    end

    assign o_side = r_side;
    assign o_exp  = r_exp;
    assign o_m    = r_m;

endmodule

@@ rtl/rpe_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// rpe_cordic_cell
// One rotation-mode CORDIC micro-rotation by atan(2^-STAGE).
// ----------------------------------------------------------------------------
module rpe_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  rpe_pkg::t_side                 i_side,
    input  logic                           i_flip,
    input  logic signed [rpe_pkg::CW-1:0]  i_x,
    input  logic signed [rpe_pkg::CW-1:0]  i_y,
    input  logic signed [rpe_pkg::CW-1:0]  i_z,
    output rpe_pkg::t_side                 o_side,
    output logic                           o_flip,
    output logic signed [rpe_pkg::CW-1:0]  o_x,
    output logic signed [rpe_pkg::CW-1:0]  o_y,
    output logic signed [rpe_pkg::CW-1:0]  o_z
);
    import rpe_pkg::*;

    localparam logic signed [CW-1:0] ANGLE = CW'(atan_turn(STAGE));

    t_side                r_side;
    logic                 r_flip;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic signed [CW-1:0] n_x;
    logic signed [CW-1:0] n_y;
    logic signed [CW-1:0] n_z;

    always_comb begin
        if (!i_z[CW-1]) begin
            n_x = i_x - (i_y >>> STAGE);
            n_y = i_y + (i_x >>> STAGE);
            n_z = i_z - ANGLE;
        end else begin
            n_x = i_x + (i_y >>> STAGE);
            n_y = i_y - (i_x >>> STAGE);
            n_z = i_z + ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flip <= i_flip;
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
        end
    end

    assign o_side = r_side;
    assign o_flip = r_flip;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

@@ rtl/rotary_position_embedding.sv @@
// Throughput: one word per cycle; the whole chain advances whenever the output
// register is empty or being taken, so o_ready is low only under back-pressure.
// The 32 divider cells, 24 exponent cells and the CORDIC cells set the depth.
// Reset (synchronous, active low) empties the chain and restores the registers.
// ----------------------------------------------------------------------------
// rotary_position_embedding
// Rotates one head-vector element pair by position * theta^(-2i/head_size),
// as a chain of divider, exponent and CORDIC cells.
// ----------------------------------------------------------------------------
module rotary_position_embedding #(
    parameter int MAX_HEAD_SIZE  = rpe_pkg::MAX_HEAD_SIZE_DEF,
    parameter int POSITION_LIMIT = rpe_pkg::POSITION_LIMIT_DEF,
    parameter int CORDIC_STAGES  = rpe_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rpe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rpe_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [rpe_pkg::POS_W-1:0]         i_position,
    input  logic [rpe_pkg::IDX_W-1:0]         i_pair_index,
    input  logic signed [rpe_pkg::DATA_W-1:0] i_x_first,
    input  logic signed [rpe_pkg::DATA_W-1:0] i_x_second,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [rpe_pkg::DATA_W-1:0] o_y_first,
    output logic signed [rpe_pkg::DATA_W-1:0] o_y_second,
    output logic [1:0]                        o_status
);
    import rpe_pkg::*;

    localparam int HALF_LIM = MAX_HEAD_SIZE / 2;
    localparam int HALF_CAP = (HALF_LIM > 255) ? 255 : HALF_LIM;
    localparam int POS_CAP  = (POSITION_LIMIT > 65535) ? 65535 : POSITION_LIMIT;
    localparam logic [HALF_W-1:0] HALF_MAX = HALF_W'(HALF_CAP);
    localparam logic [POS_W-1:0]  POS_MAX  = POS_W'(POS_CAP);
    localparam logic signed [RND_W-1:0] Y_MAX = RND_W'(64'sd2147483647);
    localparam logic signed [RND_W-1:0] Y_MIN = RND_W'(-64'sd2147483648);

    logic               w_en;
    logic [CFG_W-1:0]   r_log2_theta;
    logic [HS_W-1:0]    r_head_size;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2_theta <= LOG2_THETA_RST;
            r_head_size  <= HEAD_SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOG2_THETA: r_log2_theta <= i_cfg_data;
                CFG_HEAD_SIZE:  r_head_size  <= i_cfg_data[HS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- input stage ----------------
    logic [HALF_W-1:0]  w_half;
    t_side              n_side0;
    t_side              r_side0;
    logic [HALF_W-1:0]  r_half0;
    logic [NUM_W-1:0]   r_num0;

    always_comb begin
        w_half           = (r_head_size[HS_W-1:1] > HALF_MAX) ? HALF_MAX
                                                               : r_head_size[HS_W-1:1];
        n_side0.valid    = i_valid;
        n_side0.bad      = {1'b0, i_pair_index} >= w_half;
        n_side0.pos      = (i_position > POS_MAX) ? POS_MAX : i_position;
        n_side0.x_first  = i_x_first;
        n_side0.x_second = i_x_second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side0.valid <= 1'b0;
        end else if (w_en) begin
            r_side0 <= n_side0;
        end
    end

    // exponent = log2_theta * 2i / (2*half) = log2_theta * i / half
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_half0 <= w_half;
            r_num0  <= NUM_W'(r_log2_theta) * NUM_W'(i_pair_index);
        end
    end

    // ---------------- divider chain ----------------
    t_side              div_side [0:DIV_STEPS];
    logic [HALF_W-1:0]  div_d    [0:DIV_STEPS];
    logic [HALF_W-1:0]  div_rem  [0:DIV_STEPS];
    logic [DATA_W-1:0]  div_num  [0:DIV_STEPS];

    // quotient is below 2^32 since i < half, so the top bits start as remainder
    assign div_side[0] = r_side0;
    assign div_d[0]    = r_half0;
    assign div_rem[0]  = {1'b0, r_num0[NUM_W-1:DATA_W]};
    assign div_num[0]  = r_num0[DATA_W-1:0];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        rpe_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (div_side[g]),
            .i_div   (div_d[g]),
            .i_rem   (div_rem[g]),
            .i_num   (div_num[g]),
            .o_side  (div_side[g+1]),
            .o_div   (div_d[g+1]),
            .o_rem   (div_rem[g+1]),
            .o_num   (div_num[g+1])
        );
    end

    // ---------------- 2^-frac chain ----------------
    t_side              exp_side [0:FRAC_W];
    logic [DATA_W-1:0]  exp_e    [0:FRAC_W];
    logic [M_W-1:0]     exp_m    [0:FRAC_W];

    assign exp_side[0] = div_side[DIV_STEPS];
    assign exp_e[0]    = div_num[DIV_STEPS];
    assign exp_m[0]    = M_W'(64'h1_0000_0000);

    for (genvar g = 0; g < FRAC_W; g++) begin : g_exp
        rpe_exp_cell #(.K(g + 1)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (exp_side[g]),
            .i_exp   (exp_e[g]),
            .i_m     (exp_m[g]),
            .o_side  (exp_side[g+1]),
            .o_exp   (exp_e[g+1]),
            .o_m     (exp_m[g+1])
        );
    end

    // ---------------- frequency, angle, phase ----------------
    t_side              r_side_t;
    logic [7:0]         r_n_t;
    logic [T_W-1:0]     r_t;
    t_side              r_side_p;
    logic [7:0]         r_n_p;
    logic [P_W-1:0]     r_p;
    t_side              r_side_ph;
    logic [31:0]        r_phase;
    logic [62:0]        w_tprod;
    logic [8:0]         w_sh;

    assign w_tprod = 63'(exp_m[FRAC_W]) * 63'(INV_TWO_PI_Q32);
    assign w_sh    = 9'(r_n_p) + 9'd12;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_t.valid  <= 1'b0;
            r_side_p.valid  <= 1'b0;
            r_side_ph.valid <= 1'b0;
        end else if (w_en) begin
            r_side_t  <= exp_side[FRAC_W];
            r_side_p  <= r_side_t;
            r_side_ph <= r_side_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n_t   <= exp_e[FRAC_W][DATA_W-1:FRAC_W];
            r_t     <= w_tprod[62:20];
            r_n_p   <= r_n_t;
            r_p     <= P_W'(r_side_t.pos) * P_W'(r_t);
            r_phase <= (w_sh >= 9'(P_W)) ? 32'd0 : 32'(r_p >> w_sh);
        end
    end

    // ---------------- CORDIC chain ----------------
    t_side              cor_side [0:CORDIC_STAGES];
    logic               cor_flip [0:CORDIC_STAGES];
    logic signed [CW-1:0] cor_x  [0:CORDIC_STAGES];
    logic signed [CW-1:0] cor_y  [0:CORDIC_STAGES];
    logic signed [CW-1:0] cor_z  [0:CORDIC_STAGES];
    logic [31:0]        w_phase;

    // second and third quarter turn: rotate by a half turn, negate at the end
    assign cor_flip[0] = r_phase[31] ^ r_phase[30];
    assign w_phase     = cor_flip[0] ? (r_phase ^ 32'h8000_0000) : r_phase;
    assign cor_side[0] = r_side_ph;
    assign cor_x[0]    = CW'(CORDIC_START);
    assign cor_y[0]    = '0;
    assign cor_z[0]    = CW'(signed'(w_phase));

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        rpe_cordic_cell #(.STAGE(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_side  (cor_side[g]),
            .i_flip  (cor_flip[g]),
            .i_x     (cor_x[g]),
            .i_y     (cor_y[g]),
            .i_z     (cor_z[g]),
            .o_side  (cor_side[g+1]),
            .o_flip  (cor_flip[g+1]),
            .o_x     (cor_x[g+1]),
            .o_y     (cor_y[g+1]),
            .o_z     (cor_z[g+1])
        );
    end

    // ---------------- rotate, round, saturate ----------------
    t_side                   r_side_cs;
    logic signed [CW-1:0]    r_cos;
    logic signed [CW-1:0]    r_sin;
    t_side                   r_side_m;
    logic signed [PROD_W-1:0] r_acs;
    logic signed [PROD_W-1:0] r_bsn;
    logic signed [PROD_W-1:0] r_bcs;
    logic signed [PROD_W-1:0] r_asn;
    logic signed [ACC_W-1:0] w_acc1;
    logic signed [ACC_W-1:0] w_acc2;
    logic signed [RND_W-1:0] w_r1;
    logic signed [RND_W-1:0] w_r2;
    logic signed [DATA_W-1:0] n_y1;
    logic signed [DATA_W-1:0] n_y2;
    t_status                 n_status;
    logic                    r_o_valid;
    logic signed [DATA_W-1:0] r_y1;
    logic signed [DATA_W-1:0] r_y2;
    t_status                 r_status;

    always_comb begin
        w_acc1 = ACC_W'(r_acs) - ACC_W'(r_bsn) + ACC_W'(64'sd536870912);
        w_acc2 = ACC_W'(r_bcs) + ACC_W'(r_asn) + ACC_W'(64'sd536870912);
        w_r1   = RND_W'(w_acc1 >>> 30);
        w_r2   = RND_W'(w_acc2 >>> 30);
        n_status = ST_OK;
        if (w_r1 > Y_MAX) begin
            n_y1 = DATA_W'(Y_MAX);  n_status = ST_SAT;
        end else if (w_r1 < Y_MIN) begin
            n_y1 = DATA_W'(Y_MIN);  n_status = ST_SAT;
        end else begin
            n_y1 = DATA_W'(w_r1);
        end
        if (w_r2 > Y_MAX) begin
            n_y2 = DATA_W'(Y_MAX);  n_status = ST_SAT;
        end else if (w_r2 < Y_MIN) begin
            n_y2 = DATA_W'(Y_MIN);  n_status = ST_SAT;
        end else begin
            n_y2 = DATA_W'(w_r2);
        end
        if (r_side_m.bad) begin
            n_y1     = '0;
            n_y2     = '0;
            n_status = ST_BAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_cs.valid <= 1'b0;
            r_side_m.valid  <= 1'b0;
            r_o_valid       <= 1'b0;
        end else if (w_en) begin
            r_side_cs <= cor_side[CORDIC_STAGES];
            r_side_m  <= r_side_cs;
            r_o_valid <= r_side_m.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cos    <= cor_flip[CORDIC_STAGES] ? -cor_x[CORDIC_STAGES] : cor_x[CORDIC_STAGES];
            r_sin    <= cor_flip[CORDIC_STAGES] ? -cor_y[CORDIC_STAGES] : cor_y[CORDIC_STAGES];
            r_acs    <= PROD_W'(r_side_cs.x_first)  * PROD_W'(r_cos);
            r_bsn    <= PROD_W'(r_side_cs.x_second) * PROD_W'(r_sin);
            r_bcs    <= PROD_W'(r_side_cs.x_second) * PROD_W'(r_cos);
            r_asn    <= PROD_W'(r_side_cs.x_first)  * PROD_W'(r_sin);
            r_y1     <= n_y1;
            r_y2     <= n_y2;
            r_status <= n_status;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_y_first  = r_y1;
    assign o_y_second = r_y2;
    assign o_status   = r_status;

`ifndef ASSERT_OFF
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_BAD) |-> (o_y_first == '0) && (o_y_second == '0))
        else $error("bad index word with nonzero data");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK) || (o_status == ST_SAT) || (o_status == ST_BAD))
        else $error("undefined status code");

    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_SAT) |->
            (o_y_first == DATA_W'(Y_MAX)) || (o_y_first == DATA_W'(Y_MIN)) ||
            (o_y_second == DATA_W'(Y_MAX)) || (o_y_second == DATA_W'(Y_MIN)))
        else $error("saturated status without a clamped result");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");
`endif

endmodule

@@ bench/rpe_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpe_checker
// Watches the config port and both word channels, predicts each rotated pair
// in fixed point and compares it with the words that leave the block.
// ----------------------------------------------------------------------------
module rpe_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rpe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rpe_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_valid,
    input  logic                              i_in_ready,
    input  logic [rpe_pkg::POS_W-1:0]         i_position,
    input  logic [rpe_pkg::IDX_W-1:0]         i_pair_index,
    input  logic signed [rpe_pkg::DATA_W-1:0] i_x_first,
    input  logic signed [rpe_pkg::DATA_W-1:0] i_x_second,
    input  logic                              i_out_valid,
    input  logic                              i_ready,
    input  logic signed [rpe_pkg::DATA_W-1:0] i_y_first,
    input  logic signed [rpe_pkg::DATA_W-1:0] i_y_second,
    input  logic [1:0]                        i_status,
    output int                                o_fail_count,
    output int                                o_pending
);
    import rpe_pkg::*;

    localparam int STAGES = CORDIC_STAGES_DEF;
    localparam longint unsigned HEAD_CAP = MAX_HEAD_SIZE_DEF & ~1;
    localparam longint unsigned POS_CAP  = POSITION_LIMIT_DEF;

    typedef struct packed {
        logic signed [31:0] y_first;
        logic signed [31:0] y_second;
        logic [1:0]         status;
    } t_rotated;

    // arctangent steps, 2^32 = one turn
    localparam logic [31:0] ATAN_STEP [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    logic [31:0] theta_q;
    logic [8:0]  head_q;
    t_rotated    rotated_q[$];

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint signed round_clamp(input longint signed acc,
                                                  inout bit sat);
        longint signed r;
        r = (acc + (64'sd1 <<< 29)) >>> 30;
        if (r > 64'sd2147483647) begin
            sat = 1'b1;
            r   = 64'sd2147483647;
        end else if (r < -64'sd2147483648) begin
            sat = 1'b1;
            r   = -64'sd2147483648;
        end
        return r;
    endfunction

    function automatic t_rotated rotate_pair(input logic [15:0] pos_in,
                                             input logic [6:0] idx,
                                             input logic signed [31:0] a,
                                             input logic signed [31:0] b,
                                             input logic [31:0] theta,
                                             input logic [8:0] hsize);
        t_rotated        r;
        longint unsigned eff, pos, e, n, m, c, t, p, sh;
        logic [31:0]     phase;
        longint signed   x, y, z, nx, aa, bb;
        bit              flip, sat;
        eff = hsize & ~9'd1;
        if (eff > HEAD_CAP) eff = HEAD_CAP;
        pos = (pos_in > POS_CAP) ? POS_CAP : pos_in;
        if (idx >= eff / 2) begin
            r.y_first  = '0;
            r.y_second = '0;
            r.status   = ST_BAD;
            return r;
        end
        e = (longint'(theta) * (2 * idx)) / eff;
        n = e >> 24;
        // 2^-frac by the square root chain
        m = 64'd1 << 32;
        c = floor_sqrt(64'd1 << 63);
        for (int k = 1; k <= 24; k++) begin
            if (e[24-k]) m = (m * c + 64'h80000000) >> 32;
            c = floor_sqrt(c << 32);
        end
        t  = (m * 64'd683565275) >> 20;
        p  = pos * t;
        sh = 12 + n;
        phase = (sh >= 64) ? 32'd0 : 32'(p >> sh);
        flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
        if (flip) phase = phase ^ 32'h80000000;
        x = 64'sh26DD3B6A;
        y = 0;
        z = longint'(signed'(phase));
        for (int i = 0; i < STAGES && i < 32; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(ATAN_STEP[i]);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(ATAN_STEP[i]);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        aa  = a;
        bb  = b;
        sat = 1'b0;
        r.y_first  = 32'(round_clamp(aa * x - bb * y, sat));
        r.y_second = 32'(round_clamp(bb * x + aa * y, sat));
        r.status   = sat ? ST_SAT : ST_OK;
        return r;
    endfunction

    assign o_pending = rotated_q.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_rotated want;
        if (!i_rst_n) begin
            theta_q <= LOG2_THETA_RST;
            head_q  <= HEAD_SIZE_RST;
        end else begin
            if (i_valid && i_in_ready)
                rotated_q = {rotated_q, rotate_pair(i_position, i_pair_index, i_x_first,
                                                    i_x_second, theta_q, head_q)};
            if (i_out_valid && i_ready) begin
                if (rotated_q.size() == 0) begin
                    $display("%0t: unexpected word y_first=%h y_second=%h status=%0d",
                             $time, i_y_first, i_y_second, i_status);
                    o_fail_count++;
                end else begin
                    want = rotated_q.pop_front();
                    if (want.y_first !== i_y_first) begin
                        $display("%0t: y_first expected %h actual %h",
                                 $time, want.y_first, i_y_first);
                        o_fail_count++;
                    end
                    if (want.y_second !== i_y_second) begin
                        $display("%0t: y_second expected %h actual %h",
                                 $time, want.y_second, i_y_second);
                        o_fail_count++;
                    end
                    if (want.status !== i_status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_status);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_LOG2_THETA) theta_q <= i_cfg_data;
                else if (i_cfg_index == CFG_HEAD_SIZE) head_q <= i_cfg_data[8:0];
            end
        end
    end

endmodule

@@ bench/rotary_position_embedding_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotary_position_embedding_tb
// Drives directed and random element pairs through several theta and head
// size settings with random stalls on both channels; the checker scores it.
// ----------------------------------------------------------------------------
module rotary_position_embedding_tb;
    import rpe_pkg::*;

    localparam int DRAIN_CYCLES = 120;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_W-1:0]         i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [POS_W-1:0]         i_position = '0;
    logic [IDX_W-1:0]         i_pair_index = '0;
    logic signed [DATA_W-1:0] i_x_first = '0;
    logic signed [DATA_W-1:0] i_x_second = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [DATA_W-1:0] o_y_first;
    logic signed [DATA_W-1:0] o_y_second;
    logic [1:0]               o_status;

    int  fail_count, pending, words_sent, settings_used;
    bit  idle_on = 1'b1;
    int  stall_left = 0;
    logic [8:0] head_now = HEAD_SIZE_RST;

    always #6 i_clk = ~i_clk;

    rotary_position_embedding dut (.*);

    rpe_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_valid, .i_in_ready(o_ready), .i_position, .i_pair_index,
        .i_x_first, .i_x_second, .i_out_valid(o_valid), .i_ready,
        .i_y_first(o_y_first), .i_y_second(o_y_second), .i_status(o_status),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stalls in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 17);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [15:0] pos, input logic [6:0] idx,
                             input logic [31:0] a, input logic [31:0] b);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_position   <= pos;
        i_pair_index <= idx;
        i_x_first    <= a;
        i_x_second   <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HEAD_SIZE) head_now = val[8:0];
        settings_used++;
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 2))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 2 * 65536 * 4)) - 65536 * 4);
            default: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 255)
                                                 : 32'h80000000 + $urandom_range(0, 255);
        endcase
    endfunction

    task automatic random_words(input int count);
        int   half;
        logic [6:0] idx;
        logic [15:0] pos;
        half = int'((head_now > 9'd256) ? 9'd256 : head_now) / 2;
        repeat (count) begin
            if (half > 0 && $urandom_range(0, 9) != 0) idx = 7'($urandom_range(0, half - 1));
            else idx = 7'($urandom());
            pos = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 64));
            send_word(pos, idx, rand_elem(), rand_elem());
        end
    endtask

    initial begin
        #24_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset settings, field extremes, saturation, bad index
        send_word(16'd0, 7'd0, 32'h7FFFFFFF, 32'h80000000);
        send_word(16'hFFFF, 7'd0, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_word(16'hFFFF, 7'd63, 32'h80000000, 32'h80000000);
        send_word(16'd1, 7'd1, 32'h00010000, 32'h00000000);
        send_word(16'd3, 7'd0, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_word(16'd5, 7'd64, 32'h12345678, 32'h87654321);
        send_word(16'd100, 7'd127, 32'hFFFFFFFF, 32'h00000001);
        send_word(16'd0, 7'd0, 32'h00000000, 32'h00000000);
        // extreme theta and head size settings
        write_reg(CFG_LOG2_THETA, 32'hFFFFFFFF);
        write_reg(CFG_HEAD_SIZE, 32'd256);
        send_word(16'hFFFF, 7'd127, 32'h7FFFFFFF, 32'h80000000);
        send_word(16'h8000, 7'd1, 32'h40000000, 32'hC0000000);
        write_reg(CFG_LOG2_THETA, 32'd0);
        send_word(16'hFFFF, 7'd5, 32'h7FFFFFFF, 32'h7FFFFFFF);
        write_reg(CFG_HEAD_SIZE, 32'd511);
        send_word(16'd777, 7'd127, 32'h00010000, 32'hFFFF0000);
        write_reg(CFG_HEAD_SIZE, 32'd0);
        send_word(16'd7, 7'd0, 32'h00010000, 32'h00010000);
        write_reg(CFG_HEAD_SIZE, 32'd1);
        send_word(16'd7, 7'd0, 32'h00010000, 32'h00010000);
        write_reg(CFG_HEAD_SIZE, 32'd2);
        write_reg(CFG_LOG2_THETA, LOG2_THETA_RST);
        send_word(16'hFFFF, 7'd0, 32'h00030000, 32'hFFFD0000);
        send_word(16'hFFFF, 7'd1, 32'h00030000, 32'hFFFD0000);
        write_reg(CFG_HEAD_SIZE, 32'd7);
        send_word(16'd12345, 7'd2, 32'h7FFFFFFF, 32'h00000000);
        send_word(16'd12345, 7'd3, 32'h7FFFFFFF, 32'h00000000);

        // random phases, each with fresh settings
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_LOG2_THETA, $urandom_range(0, 1) ? $urandom()
                                      : 32'($urandom_range(10, 20)) << 24);
            write_reg(CFG_HEAD_SIZE, $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 511))
                                     : 32'(2 * $urandom_range(1, 128)));
            random_words(40);
            if (ph == 1) begin
                // hold the sender until the chain is empty
                i_valid <= 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            random_words(40);
        end

        // final stretch at full rate
        write_reg(CFG_LOG2_THETA, LOG2_THETA_RST);
        write_reg(CFG_HEAD_SIZE, 32'(HEAD_SIZE_RST));
        idle_on = 1'b0;
        random_words(90);

        drain();
        $display("Sent %0d words across %0d register writes, with stalls on both sides.",
                 words_sent, settings_used);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ rotary_position_embedding.f @@
rtl/rpe_pkg.sv
rtl/rpe_div_cell.sv
rtl/rpe_exp_cell.sv
rtl/rpe_cordic_cell.sv
rtl/rotary_position_embedding.sv
bench/rpe_checker.sv
bench/rotary_position_embedding_tb.sv
